// File: rtl/kda_pkg.sv
// Shared types, codes and reset values for the key debounce and auto-repeat block.
package kda_pkg;

	localparam int KDA_NUM_KEYS    = 32;
	localparam int KDA_COUNT_WIDTH = 16;
	localparam int CMP_WIDTH       = 33;
	localparam int TICKS_WIDTH     = 16;
	localparam int MASK_WIDTH      = 32;
	localparam int TIME_WIDTH      = 16;

	localparam logic [TICKS_WIDTH-1:0] DEBOUNCE_RESET   = 16'd20;
	localparam logic [TICKS_WIDTH-1:0] LONG_PRESS_RESET = 16'd500;
	localparam logic [TICKS_WIDTH-1:0] REPEAT_RESET     = 16'd150;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_POLL = 2'd1,
		CMD_READ = 2'd2,
		CMD_ZERO = 2'd3
	} kda_cmd_e;

	typedef enum logic [2:0] {
		REG_LOCK_MASK     = 3'd0,
		REG_PRESS_RELEASE = 3'd1,
		REG_LONG_PRESS    = 3'd2,
		REG_DEBOUNCE      = 3'd3,
		REG_LONG_TICKS    = 3'd4,
		REG_REPEAT        = 3'd5
	} kda_reg_e;

	typedef struct packed {
		logic [TICKS_WIDTH-1:0] debounce_ticks;
		logic [TICKS_WIDTH-1:0] long_press_ticks;
		logic [TICKS_WIDTH-1:0] repeat_ticks;
	} kda_thr_t;

	typedef struct packed {
		logic tick;
		logic poll;
		logic zero;
		logic sel;
		logic held;
		logic is_lock;
		logic is_pr;
		logic is_lp;
	} kda_lane_ctl_t;

endpackage

// File: rtl/kda_lane.sv
// One key lane: hold counter and event flag with debounce, lock and auto-repeat update.
module kda_lane
	import kda_pkg::*;
#(
	parameter int COUNT_WIDTH = KDA_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd,
	input  kda_lane_ctl_t          ctl,
	input  kda_thr_t               thr,
	output logic                   flag,
	output logic [COUNT_WIDTH-1:0] count
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   flag_q;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   flag_d;
	logic [CMP_WIDTH-1:0]   deb_x;
	logic [CMP_WIDTH-1:0]   long_x;
	logic [CMP_WIDTH-1:0]   rep_point;

	assign deb_x     = CMP_WIDTH'(thr.debounce_ticks);
	assign long_x    = CMP_WIDTH'(thr.long_press_ticks);
	assign rep_point = long_x + CMP_WIDTH'(thr.repeat_ticks);

	always_comb begin
		count_d = count_q;
		flag_d  = flag_q;
		if (ctl.tick) begin
			if (ctl.is_lock) begin
				flag_d = ctl.held;
			end
			if (ctl.is_pr) begin
				if (ctl.held) begin
					if (count_d != CNT_MAX) begin
						count_d = count_d + 1'b1;
						if (CMP_WIDTH'(count_d) == deb_x) begin
							flag_d = 1'b1;
						end
					end
				end else begin
					count_d = '0;
					flag_d  = 1'b0;
				end
			end
			if (ctl.is_lp) begin
				if (ctl.held) begin
					if (count_d != CNT_MAX) begin
						count_d = count_d + 1'b1;
						if (CMP_WIDTH'(count_d) == deb_x || CMP_WIDTH'(count_d) == long_x) begin
							flag_d = 1'b1;
						end else if (CMP_WIDTH'(count_d) == rep_point) begin
							count_d = COUNT_WIDTH'(long_x);
							flag_d  = 1'b1;
						end
					end
				end else begin
					count_d = '0;
					flag_d  = 1'b0;
				end
			end
		end else if (ctl.sel) begin
			if (ctl.poll && !ctl.is_lock) begin
				flag_d = 1'b0;
			end
			if (ctl.zero) begin
				count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q  <= 1'b0;
		end else if (upd) begin
			count_q <= count_d;
			flag_q  <= flag_d;
		end
	end

	assign flag  = flag_q;
	assign count = count_q;

endmodule

// File: rtl/kda_merge.sv
// Merging stage: pick the addressed lane's flag or counter and hold the result item.
module kda_merge
	import kda_pkg::*;
#(
	parameter int NUM_KEYS    = KDA_NUM_KEYS,
	parameter int COUNT_WIDTH = KDA_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  kda_cmd_e               cmd,
	input  logic [NUM_KEYS-1:0]    sel,
	input  logic [NUM_KEYS-1:0]    flags,
	input  logic [COUNT_WIDTH-1:0] counts [NUM_KEYS],
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic                   pressed,
	output logic [TIME_WIDTH-1:0]  press_time
);

	logic                  out_valid_q;
	logic                  pressed_q;
	logic [TIME_WIDTH-1:0] press_time_q;
	logic                  hit_flag;
	logic [CMP_WIDTH-1:0]  hit_count;

	always_comb begin
		hit_flag  = |(sel & flags);
		hit_count = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (sel[k]) begin
				hit_count = hit_count | CMP_WIDTH'(counts[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pressed_q    <= (cmd == CMD_POLL) ? hit_flag : 1'b0;
			press_time_q <= (cmd == CMD_READ) ? hit_count[TIME_WIDTH-1:0] : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign pressed    = pressed_q;
	assign press_time = press_time_q;

endmodule

// File: rtl/key_debounce_autorepeat_top.sv
// Top level of the key debounce and auto-repeat block: registers, lanes and merge.
//
// Input items arrive on in_valid/in_ready with command, raw_keys and key_index.
// A tick updates every key lane side by side; poll, read and zero address one
// key. Each item yields exactly one result item on out_valid/out_ready carrying
// pressed and press_time.
// The result is registered at the edge that accepts the item and shows on the
// next cycle. One item per cycle is accepted while out_ready keeps the result
// register draining, as the lanes update at the accepting edge and it holds one entry.
// in_ready stays high while the result register is empty or being emptied, so
// a stalled receiver holds the result and blocks only the following item.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and writes belong to idle periods.
// Reset clears every hold counter, every event flag and the key class masks,
// and loads the default debounce, long-press and repeat tick counts.
module key_debounce_autorepeat_top
	import kda_pkg::*;
#(
	parameter int NUM_KEYS    = KDA_NUM_KEYS,
	parameter int COUNT_WIDTH = KDA_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            command,
	input  logic [MASK_WIDTH-1:0] raw_keys,
	input  logic [4:0]            key_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  pressed,
	output logic [TIME_WIDTH-1:0] press_time,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [MASK_WIDTH-1:0] cfg_data
);

	logic [MASK_WIDTH-1:0] lock_mask_q;
	logic [MASK_WIDTH-1:0] pr_mask_q;
	logic [MASK_WIDTH-1:0] lp_mask_q;
	kda_thr_t              thr_q;
	logic                  accept;
	kda_cmd_e              cmd;
	logic [NUM_KEYS-1:0]   sel;
	logic [NUM_KEYS-1:0]   flags;
	logic [COUNT_WIDTH-1:0] counts [NUM_KEYS];

	assign cfg_ready = 1'b1;
	assign cmd       = kda_cmd_e'(command);
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_mask_q <= '0;
			pr_mask_q   <= '0;
			lp_mask_q   <= '0;
			thr_q.debounce_ticks   <= DEBOUNCE_RESET;
			thr_q.long_press_ticks <= LONG_PRESS_RESET;
			thr_q.repeat_ticks     <= REPEAT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (kda_reg_e'(cfg_index))
				REG_LOCK_MASK:     lock_mask_q <= cfg_data;
				REG_PRESS_RELEASE: pr_mask_q   <= cfg_data;
				REG_LONG_PRESS:    lp_mask_q   <= cfg_data;
				REG_DEBOUNCE:      thr_q.debounce_ticks   <= cfg_data[TICKS_WIDTH-1:0];
				REG_LONG_TICKS:    thr_q.long_press_ticks <= cfg_data[TICKS_WIDTH-1:0];
				REG_REPEAT:        thr_q.repeat_ticks     <= cfg_data[TICKS_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		kda_lane_ctl_t ctl;

		assign sel[k]      = (key_index == 5'(k));
		assign ctl.tick    = (cmd == CMD_TICK);
		assign ctl.poll    = (cmd == CMD_POLL);
		assign ctl.zero    = (cmd == CMD_ZERO);
		assign ctl.sel     = sel[k];
		assign ctl.held    = !raw_keys[k];
		assign ctl.is_lock = lock_mask_q[k];
		assign ctl.is_pr   = pr_mask_q[k];
		assign ctl.is_lp   = lp_mask_q[k];

		kda_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.upd   (accept),
			.ctl   (ctl),
			.thr   (thr_q),
			.flag  (flags[k]),
			.count (counts[k])
		);
	end

	kda_merge #(
		.NUM_KEYS   (NUM_KEYS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.sel       (sel),
		.flags     (flags),
		.counts    (counts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.pressed   (pressed),
		.press_time(press_time)
	);

	assign in_ready = !out_valid || out_ready;

endmodule
